>>> hw/rtl/dlfb_pkg.sv
// Shared constants, codes and arithmetic helpers of the dense layer unit.
package dlfb_pkg;

	localparam int N_IN  = 16;
	localparam int N_OUT = 16;
	localparam int BATCH = 32;

	localparam int NW   = N_IN * N_OUT;
	localparam int NB   = BATCH * N_IN;
	localparam int IW   = (N_IN > 1) ? $clog2(N_IN) : 1;
	localparam int OW   = (N_OUT > 1) ? $clog2(N_OUT) : 1;
	localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int BAW  = (NB > 1) ? $clog2(NB) : 1;
	localparam int KMAX = (N_IN > N_OUT) ? N_IN : N_OUT;
	localparam int KW   = $clog2(KMAX + 1);
	localparam int LN   = NW + N_OUT;
	localparam int LW   = $clog2(LN + 1);

	localparam logic [2:0] CMD_LOAD_W = 3'd0;
	localparam logic [2:0] CMD_LOAD_B = 3'd1;
	localparam logic [2:0] CMD_INPUT  = 3'd2;
	localparam logic [2:0] CMD_GRAD   = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;
	localparam logic [2:0] CMD_LOSS   = 3'd5;

	localparam logic [2:0] KIND_OUT   = 3'd0;
	localparam logic [2:0] KIND_IGRAD = 3'd1;
	localparam logic [2:0] KIND_WGRAD = 3'd2;
	localparam logic [2:0] KIND_BGRAD = 3'd3;
	localparam logic [2:0] KIND_LOSS  = 3'd4;

	localparam logic [1:0] REG_WL1 = 2'd0;
	localparam logic [1:0] REG_WL2 = 2'd1;
	localparam logic [1:0] REG_BL1 = 2'd2;
	localparam logic [1:0] REG_BL2 = 2'd3;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;

	// Q4.12 product, floor toward minus infinity
	function automatic logic signed [19:0] qmul(logic signed [15:0] a, logic signed [15:0] b);
		logic signed [31:0] p;
		p = a * b;
		return 20'(p >>> 12);
	endfunction

	function automatic logic signed [31:0] sat_add32(logic signed [31:0] acc,
			logic signed [19:0] b);
		logic signed [33:0] s;
		s = 34'(acc) + 34'(b);
		if (s > 34'sh0_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (s < -34'sh0_8000_0000)
			return 32'sh8000_0000;
		else
			return s[31:0];
	endfunction

	// sign(w)*l1 >> 4 + l2*w >> 15, both floored
	function automatic logic signed [19:0] reg_term(logic signed [15:0] w,
			logic [15:0] l1, logic [15:0] l2);
		logic signed [16:0] sl;
		logic signed [32:0] p;
		sl = (w > 0) ? $signed({1'b0, l1}) : ((w < 0) ? -$signed({1'b0, l1}) : 17'sd0);
		p  = $signed({1'b0, l2}) * w;
		return 20'(sl >>> 4) + 20'(p >>> 15);
	endfunction

endpackage

>>> hw/rtl/dlfb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module dlfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/dense_layer_forward_backward_unit.sv
// Top level of the dense layer forward/backward unit.
// One item is processed at a time; the input side stalls from acceptance until the item
// is finished, for an item with results until its last result is loaded into the output
// register. Weight loads, bias loads and ignored items give no result. An input element
// reads the weight RAM once per neuron, and emits N_OUT outputs when it ends a row. A
// gradient element emits N_IN input gradients when it ends a row. A gradient read gives
// one result; a loss query sums over all weights and biases into one result.
// Gradient accumulators need no clearing pass: per-entry valid bits are cleared at reset
// and at the start of a batch.
module dense_layer_forward_backward_unit
	import dlfb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [5:0]         input_index,
	input  logic [5:0]         neuron_index,
	input  logic [5:0]         sample_index,
	input  logic signed [15:0] value,
	input  logic               first_of_pass,
	input  logic               last_of_group,
	input  logic               read_bias,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [5:0]         index,
	output logic signed [47:0] result,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_ACC  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] cmd_q;
	logic [5:0] i_q, n_q, s_q;
	logic signed [15:0] v_q;
	logic first_q, lastg_q, rbias_q;
	logic [KW-1:0] k_q;
	logic [LW-1:0] kk_q;
	logic [15:0] wl1_q, wl2_q, bl1_q, bl2_q;

	logic signed [15:0] bias_q [N_OUT];
	logic signed [31:0] oacc_q [N_OUT];
	logic signed [31:0] igacc_q [N_IN];
	logic signed [31:0] bgacc_q [N_OUT];
	logic [NW-1:0] wg_vld_q;

	logic signed [19:0] p1_q, p2_q, rt_q;
	logic signed [31:0] old_q, base_q;
	logic [31:0] m1_q, m2_q;
	logic [63:0] tot_q;
	logic ok_q;

	logic out_valid_q;
	logic [2:0] kind_q;
	logic [5:0] index_q;
	logic signed [47:0] result_q;
	logic last_q;

	logic i_ok, n_ok, s_ok;
	logic [WAW-1:0] w_addr, wg_addr;
	logic [BAW-1:0] b_waddr, b_raddr;
	logic w_we, b_we, wg_we;
	logic [15:0] w_rdata, x_rdata;
	logic [31:0] wg_rdata, wg_wdata;
	logic [OW-1:0] bsel;
	logic signed [15:0] bias_rd;
	logic out_load, out_last;
	logic signed [15:0] lw;
	logic [15:0] la;
	logic [LW-1:0] kk_b;

	assign i_ok = ({1'b0, i_q} < 7'(N_IN));
	assign n_ok = ({1'b0, n_q} < 7'(N_OUT));
	assign s_ok = ({1'b0, s_q} < 7'(BATCH));

	always_comb begin
		case (cmd_q)
			CMD_INPUT: w_addr = WAW'(32'(i_q) * N_OUT + 32'(k_q));
			CMD_GRAD:  w_addr = WAW'(32'(k_q) * N_OUT + 32'(n_q));
			CMD_LOSS:  w_addr = WAW'(kk_q);
			default:   w_addr = WAW'(32'(i_q) * N_OUT + 32'(n_q));
		endcase
	end
	assign wg_addr = (cmd_q == CMD_GRAD) ? WAW'(32'(k_q) * N_OUT + 32'(n_q))
	                                     : WAW'(32'(i_q) * N_OUT + 32'(n_q));
	assign b_waddr = BAW'(32'(s_q) * N_IN + 32'(i_q));
	assign b_raddr = BAW'(32'(s_q) * N_IN + 32'(k_q));

	assign w_we  = (state_q == S_DEC) && (cmd_q == CMD_LOAD_W) && i_ok && n_ok;
	assign b_we  = (state_q == S_DEC) && (cmd_q == CMD_INPUT) && i_ok && s_ok;
	assign wg_we = (state_q == S_ACC) && (cmd_q == CMD_GRAD);
	assign wg_wdata = sat_add32(old_q, p1_q);

	dlfb_ram #(.WIDTH(16), .DEPTH(NW)) u_wram (
		.clk(clk), .we(w_we), .waddr(w_addr), .wdata(v_q),
		.raddr(w_addr), .rdata(w_rdata));
	dlfb_ram #(.WIDTH(16), .DEPTH(NB)) u_xram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(v_q),
		.raddr(b_raddr), .rdata(x_rdata));
	dlfb_ram #(.WIDTH(32), .DEPTH(NW)) u_gram (
		.clk(clk), .we(wg_we), .waddr(wg_addr), .wdata(wg_wdata),
		.raddr(wg_addr), .rdata(wg_rdata));

	// single bias read port, shared by the input, read and loss commands
	assign kk_b = kk_q - LW'(NW);
	always_comb begin
		case (cmd_q)
			CMD_INPUT: bsel = k_q[OW-1:0];
			CMD_LOSS:  bsel = kk_b[OW-1:0];
			default:   bsel = n_q[OW-1:0];
		endcase
	end
	assign bias_rd = bias_q[bsel];

	// loss operand: weights first, then biases
	assign lw = (kk_q < LW'(NW)) ? $signed(w_rdata) : bias_rd;
	assign la = lw[15] ? 16'(~lw + 16'd1) : 16'(lw);

	assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	always_comb begin
		case (cmd_q)
			CMD_INPUT: out_last = (k_q == KW'(N_OUT - 1));
			CMD_GRAD:  out_last = (k_q == KW'(N_IN - 1));
			default:   out_last = 1'b1;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign index     = index_q;
	assign result    = result_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl1_q <= '0;
			wl2_q <= '0;
			bl1_q <= '0;
			bl2_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WL1: wl1_q <= cfg_data;
				REG_WL2: wl2_q <= cfg_data;
				REG_BL1: bl1_q <= cfg_data;
				REG_BL2: bl2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			kk_q        <= '0;
			wg_vld_q    <= '0;
			for (int j = 0; j < N_OUT; j++) begin
				oacc_q[j]  <= '0;
				bgacc_q[j] <= '0;
			end
			for (int j = 0; j < N_IN; j++)
				igacc_q[j] <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						i_q     <= input_index;
						n_q     <= neuron_index;
						s_q     <= sample_index;
						v_q     <= value;
						first_q <= first_of_pass;
						lastg_q <= last_of_group;
						rbias_q <= read_bias;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					k_q     <= '0;
					kk_q    <= '0;
					tot_q   <= '0;
					state_q <= S_IDLE;
					case (cmd_q)
						CMD_LOAD_B: begin
							if (n_ok)
								bias_q[n_q[OW-1:0]] <= v_q;
						end
						CMD_INPUT: begin
							if (i_ok && s_ok) begin
								if (first_q)
									for (int j = 0; j < N_OUT; j++)
										oacc_q[j] <= '0;
								state_q <= S_RD;
							end
						end
						CMD_GRAD: begin
							if (n_ok && s_ok) begin
								if (first_q) begin
									wg_vld_q <= '0;
									for (int j = 0; j < N_OUT; j++)
										bgacc_q[j] <= '0;
									for (int j = 0; j < N_IN; j++)
										igacc_q[j] <= '0;
								end
								bgacc_q[n_q[OW-1:0]] <= sat_add32(
									first_q ? 32'sd0 : bgacc_q[n_q[OW-1:0]], 20'(v_q));
								state_q <= S_RD;
							end
						end
						CMD_READ, CMD_LOSS: state_q <= S_RD;
						default: ;
					endcase
				end
				S_RD: state_q <= S_MUL;
				S_MUL: begin
					state_q <= S_ACC;
					case (cmd_q)
						CMD_INPUT: p1_q <= qmul(v_q, $signed(w_rdata));
						CMD_GRAD: begin
							p1_q  <= qmul($signed(x_rdata), v_q);
							p2_q  <= qmul(v_q, $signed(w_rdata));
							old_q <= wg_vld_q[wg_addr] ? $signed(wg_rdata) : 32'sd0;
						end
						CMD_READ: begin
							if (rbias_q) begin
								ok_q   <= n_ok;
								base_q <= bgacc_q[n_q[OW-1:0]];
								rt_q   <= reg_term(bias_rd, bl1_q, bl2_q);
							end else begin
								ok_q   <= i_ok && n_ok;
								base_q <= wg_vld_q[wg_addr] ? $signed(wg_rdata) : 32'sd0;
								rt_q   <= reg_term($signed(w_rdata), wl1_q, wl2_q);
							end
						end
						default: begin
							m1_q <= la * ((kk_q < LW'(NW)) ? wl1_q : bl1_q);
							m2_q <= la * la;
						end
					endcase
				end
				S_ACC: begin
					state_q <= S_RD;
					case (cmd_q)
						CMD_INPUT: begin
							oacc_q[k_q[OW-1:0]] <= sat_add32(oacc_q[k_q[OW-1:0]], p1_q);
							k_q <= k_q + KW'(1);
							if (k_q == KW'(N_OUT - 1)) begin
								k_q     <= '0;
								state_q <= lastg_q ? S_EMIT : S_IDLE;
							end
						end
						CMD_GRAD: begin
							wg_vld_q[wg_addr] <= 1'b1;
							igacc_q[k_q[IW-1:0]] <= sat_add32(igacc_q[k_q[IW-1:0]], p2_q);
							k_q <= k_q + KW'(1);
							if (k_q == KW'(N_IN - 1)) begin
								k_q     <= '0;
								state_q <= lastg_q ? S_EMIT : S_IDLE;
							end
						end
						CMD_READ: state_q <= S_EMIT;
						default: begin
							tot_q <= tot_q + 64'({m1_q, 12'b0})
								+ 64'(m2_q) * 64'((kk_q < LW'(NW)) ? wl2_q : bl2_q);
							kk_q <= kk_q + LW'(1);
							if (kk_q == LW'(LN - 1))
								state_q <= S_EMIT;
						end
					endcase
				end
				S_EMIT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						last_q      <= out_last;
						k_q         <= k_q + KW'(1);
						if (out_last)
							state_q <= S_IDLE;
						case (cmd_q)
							CMD_INPUT: begin
								kind_q   <= KIND_OUT;
								index_q  <= 6'(k_q);
								result_q <= 48'(oacc_q[k_q[OW-1:0]]) + 48'(bias_rd);
								if (out_last)
									for (int j = 0; j < N_OUT; j++)
										oacc_q[j] <= '0;
							end
							CMD_GRAD: begin
								kind_q   <= KIND_IGRAD;
								index_q  <= 6'(k_q);
								result_q <= 48'(igacc_q[k_q[IW-1:0]]);
								if (out_last)
									for (int j = 0; j < N_IN; j++)
										igacc_q[j] <= '0;
							end
							CMD_READ: begin
								kind_q   <= rbias_q ? KIND_BGRAD : KIND_WGRAD;
								index_q  <= n_q;
								result_q <= ok_q ? 48'(base_q) + 48'(rt_q) : 48'sd0;
							end
							default: begin
								kind_q   <= KIND_LOSS;
								index_q  <= '0;
								result_q <= ((tot_q >> 28) > 64'(MAX48)) ? MAX48
								          : $signed(48'(tot_q >> 28));
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_DEC)
		else $error("accepted item not decoded");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> k_q <= KW'(KMAX))
		else $error("row counter out of range");
	a_kk_range: assert property (@(posedge clk) disable iff (!arst_n)
		kk_q <= LW'(LN))
		else $error("loss counter out of range");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_last |=> state_q == S_IDLE && out_valid && last)
		else $error("last result did not end the item");
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_EMIT)
		else $error("result shown outside emit");
endmodule
